// ----- src/art_pkg.sv -----
// Package for the aging route table: function codes, status codes, config
// register indices and the front-to-back command struct. No dependencies.
`default_nettype none
package art_pkg;
  typedef enum logic [2:0] {
    FN_INSERT  = 3'd0,
    FN_LOOKUP  = 3'd1,
    FN_MARK    = 3'd2,
    FN_NEXT    = 3'd3,
    FN_RESTART = 3'd4,
    FN_FLUSH   = 3'd5,
    FN_TICK    = 3'd6,
    FN_NOP     = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  localparam int unsigned CfgOwn    = 0;
  localparam int unsigned CfgExpire = 1;
  localparam int unsigned CfgShare  = 2;

  typedef struct packed {
    func_t       func;
    logic [15:0] dest;
    logic [15:0] hop;
  } cmd_t;
endpackage
`default_nettype wire

// ----- src/art_front.sv -----
// Front end of the aging route table: a two-entry command queue toward the
// table. Depends on art_pkg.
`default_nettype none
module art_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire art_pkg::cmd_t in_cmd,
  output logic               q_valid,
  input  wire logic          q_ready,
  output art_pkg::cmd_t      q_cmd
);
  import art_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- src/art_back.sv -----
// Back end of the aging route table: the compacting slot array, its parallel
// compare and countdown logic, and the output register. Depends on art_pkg.
`default_nettype none
module art_back #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire art_pkg::cmd_t q_cmd,
  input  wire logic [15:0]   own_address,
  input  wire logic [15:0]   expire_ticks,
  input  wire logic [15:0]   share_ticks,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         status,
  output logic [15:0]        hop_out,
  output logic [15:0]        share_addr,
  output logic [4:0]         entry_count
);
  import art_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [15:0] slot_dest   [TABLE_DEPTH];
  logic [15:0] slot_hop    [TABLE_DEPTH];
  logic [15:0] share_left  [TABLE_DEPTH];
  logic        share_armed [TABLE_DEPTH];
  logic [15:0] expire_left [TABLE_DEPTH];
  logic [CW-1:0] count;

  logic [TABLE_DEPTH-1:0] hit;
  logic [TABLE_DEPTH-1:0] hit1;
  logic [TABLE_DEPTH-1:0] due;
  logic [TABLE_DEPTH-1:0] due1;
  logic [TABLE_DEPTH-1:0] keep;
  logic [CW-1:0] pos [TABLE_DEPTH];
  logic [CW-1:0] keep_cnt;
  logic          any_hit;
  logic          any_due;
  logic [15:0]   hit_hop;
  logic [15:0]   due_dest;
  logic          go;
  logic [15:0]   exp_load;

  assign q_ready  = !out_valid || out_ready;
  assign go       = q_valid && q_ready;
  assign exp_load = expire_ticks;

  // Parallel match, first-hit and compaction positions across all slots.
  always_comb begin
    logic [CW-1:0] p;
    hit_hop  = '0;
    due_dest = own_address;
    p        = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit[i]  = slot_valid[i] && (slot_dest[i] == q_cmd.dest);
      due[i]  = slot_valid[i] && (share_left[i] == 16'd0);
      keep[i] = slot_valid[i] && (expire_left[i] > 16'd1);
      pos[i]  = p;
      p       = p + CW'(keep[i]);
    end
    keep_cnt = p;
    hit1 = hit & (~hit + 1'b1);
    due1 = due & (~due + 1'b1);
    any_hit = |hit;
    any_due = |due;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit1[i]) hit_hop = slot_hop[i];
      if (due1[i]) due_dest = slot_dest[i];
    end
    if (!any_due) due_dest = own_address;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status     <= ST_DONE;
      hop_out    <= '0;
      share_addr <= '0;
      unique case (q_cmd.func)
        FN_INSERT: begin
          if (any_hit) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (hit1[i]) begin
                slot_hop[i]    <= q_cmd.hop;
                expire_left[i] <= exp_load;
              end
            end
          end else if (count < CW'(TABLE_DEPTH)) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (count == CW'(i)) begin
                slot_dest[i]   <= q_cmd.dest;
                slot_hop[i]    <= q_cmd.hop;
                share_left[i]  <= '0;
                share_armed[i] <= 1'b0;
                expire_left[i] <= exp_load;
              end
            end
            status <= ST_ADDED;
          end else begin
            status <= ST_FULL;
          end
        end
        FN_LOOKUP: begin
          if (any_hit) hop_out <= hit_hop;
          else status <= ST_MISS;
        end
        FN_MARK: begin
          if (any_hit) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (hit1[i]) begin
                share_left[i]  <= share_ticks;
                share_armed[i] <= 1'b1;
              end
            end
          end else begin
            status <= ST_MISS;
          end
        end
        FN_NEXT: share_addr <= due_dest;
        FN_RESTART: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            share_left[i]  <= share_armed[i] ? share_ticks : 16'd0;
            expire_left[i] <= exp_load;
          end
        end
        FN_TICK: begin
          // Survivors move down to their compacted position.
          for (int j = 0; j < TABLE_DEPTH; j++) begin
            for (int i = j; i < TABLE_DEPTH; i++) begin
              if (keep[i] && pos[i] == CW'(j)) begin
                slot_dest[j]   <= slot_dest[i];
                slot_hop[j]    <= slot_hop[i];
                share_armed[j] <= share_armed[i];
                share_left[j]  <= (share_left[i] != 16'd0) ?
                                  share_left[i] - 16'd1 : 16'd0;
                expire_left[j] <= expire_left[i] - 16'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (rst) begin
      out_valid   <= 1'b0;
      slot_valid  <= '0;
      count       <= '0;
      entry_count <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (go) begin
        out_valid <= 1'b1;
        case (q_cmd.func)
          FN_INSERT: begin
            if (!any_hit && count < CW'(TABLE_DEPTH)) begin
              for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (count == CW'(i)) slot_valid[i] <= 1'b1;
              end
              count       <= count + 1'b1;
              entry_count <= 5'(count + 1'b1);
            end else begin
              entry_count <= 5'(count);
            end
          end
          FN_FLUSH: begin
            slot_valid  <= '0;
            count       <= '0;
            entry_count <= '0;
          end
          FN_TICK: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              slot_valid[i] <= (CW'(i) < keep_cnt);
            end
            count       <= keep_cnt;
            entry_count <= 5'(keep_cnt);
          end
          default: entry_count <= 5'(count);
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/aging_route_table.sv -----
// Top level of the aging route table: configuration registers, front end
// and back end. Depends on art_pkg, art_front and art_back.
//
// Usage: items (func, dest_addr, hop_in) arrive on the in_valid/in_ready
// channel; each transfer yields exactly one result (status, hop_out,
// share_addr, entry_count) on the out_valid/out_ready channel, in order.
// The front end holds a two-entry command queue, so a new item transfers
// while a finished result still waits in the output register.
// An item is written into the queue and applied to the table from its head;
// the result is then registered in the output register, which raises
// out_valid. Throughput is one item per cycle while the receiver does not
// stall; every slot compares and counts down in parallel, and the table is
// compacted on a tick in the same cycle.
// Registers own_address, expire_ticks and share_ticks are written on the
// cfg channel (cfg_index 0, 1, 2), which is always ready; they should be
// written only while the block is idle.
// Reset empties the table and loads the register defaults. When the
// receiver stalls, the output register holds, the queue fills and
// in_ready drops after two further items.
`default_nettype none
module aging_route_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [15:0] dest_addr,
  input  wire logic [15:0] hop_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [15:0]      hop_out,
  output logic [15:0]      share_addr,
  output logic [4:0]       entry_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import art_pkg::*;

  logic [15:0] own_address;
  logic [15:0] expire_ticks;
  logic [15:0] share_ticks;
  cmd_t        in_cmd;
  cmd_t        q_cmd;
  logic        q_valid;
  logic        q_ready;

  assign cfg_ready = 1'b1;
  assign in_cmd = '{func: func_t'(func), dest: dest_addr, hop: hop_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= 16'd0;
      expire_ticks <= 16'd1024;
      share_ticks  <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        2'(CfgOwn):    own_address  <= cfg_data;
        2'(CfgExpire): expire_ticks <= cfg_data;
        2'(CfgShare):  share_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  art_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  art_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .own_address, .expire_ticks, .share_ticks,
    .out_valid, .out_ready, .status, .hop_out, .share_addr, .entry_count
  );
endmodule
`default_nettype wire

// ----- src/art_checker.sv -----
// Port-level checker for the aging route table, bound to the top level.
// Depends on the top level's ports and on art_pkg for the status codes.
`default_nettype none
module art_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [15:0] hop_out,
  input wire logic [4:0]  entry_count
);
  import art_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result changed while stalled");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 5'd16)
    else $error("entry count out of range");
  a_hop: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> hop_out == 16'd0)
    else $error("hop on failed status");
  a_add: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ADDED |-> entry_count != 5'd0)
    else $error("added entry but table empty");
endmodule

bind aging_route_table art_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .status, .hop_out, .entry_count
);
`default_nettype wire
